FILE: sv/box_mean_filter_3x3_unit_assert.svh
// ----------------------------------------------------------------------------
// box_mean_filter_3x3_unit_assert.svh
// Assertion macros used by the checker file of the mean filter.
// ----------------------------------------------------------------------------
`ifndef BOX_MEAN_FILTER_3X3_UNIT_ASSERT_SVH
`define BOX_MEAN_FILTER_3X3_UNIT_ASSERT_SVH

// antecedent holds, consequent must hold in the next cycle
`define BMF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// antecedent holds, consequent must hold in the same cycle
`define BMF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// state right after a reset cycle
`define BMF_ASSERT_RESET(lbl, clk, rst, cons, msg) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Types and constants shared by the 3x3 box mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

  localparam int MAX_WIDTH_DEF   = 128;
  localparam int PIXEL_BITS_DEF  = 8;
  localparam int HEIGHT_LIMIT    = 1024;
  localparam int ROW_BITS        = $clog2(HEIGHT_LIMIT);
  localparam int CFG_WIDTH_BITS  = 8;
  localparam int CFG_HEIGHT_BITS = 11;
  localparam int CFG_DATA_BITS   = 11;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int WIDTH_RESET     = 80;
  localparam int HEIGHT_RESET    = 21;

  localparam logic REQ_PIXEL = 1'b0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TAIL,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic take_pixel;
    logic start;
    logic read;
    logic mul;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic is_pixel;
    logic out_due;
    logic full;
    logic rd_done;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/bmf_pix_if.sv
// ----------------------------------------------------------------------------
// bmf_pix_if
// Input channel: pixel or drain request with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmf_pix_if #(
  parameter int PIXEL_BITS = bmf_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, output req_type, output pixel_value, input ready);
  modport sink (input valid, input req_type, input pixel_value, output ready);
endinterface

`default_nettype wire

FILE: sv/bmf_mean_if.sv
// ----------------------------------------------------------------------------
// bmf_mean_if
// Output channel: filtered pixel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmf_mean_if #(
  parameter int PIXEL_BITS = bmf_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] mean_value;
  logic                  frame_last;

  modport source (output valid, output mean_value, output frame_last, input ready);
  modport sink (input valid, input mean_value, input frame_last, output ready);
endinterface

`default_nettype wire

FILE: sv/bmf_ram.sv
// ----------------------------------------------------------------------------
// bmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/bmf_ctrl.sv
// ----------------------------------------------------------------------------
// bmf_ctrl
// Sequencer: takes an item; for one with a result runs nine neighbor reads, scales, loads result.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bmf_pkg::status_t  status,
  output bmf_pkg::cmd_t     cmd
);
  import bmf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.is_pixel) begin
            cmd.take_pixel = 1'b1;
            if (status.out_due) begin
              cmd.start  = 1'b1;
              state_next = ST_READ;
            end
          end else if (status.full) begin
            // drain item: push out the next pending result
            cmd.start  = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.read = 1'b1;
        if (status.rd_done) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register frees up
        if (!status.out_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/bmf_datapath.sv
// ----------------------------------------------------------------------------
// bmf_datapath
// Pixel ring buffer, position counters, neighbor sum and mean scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_datapath #(
  parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = bmf_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bmf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bmf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                req_type,
  input  logic [PIXEL_BITS-1:0]               pixel_value,
  input  bmf_pkg::cmd_t                       cmd,
  output bmf_pkg::status_t                    status,
  output logic                                mean_valid,
  input  logic                                mean_ready,
  output logic [PIXEL_BITS-1:0]               mean_value,
  output logic                                frame_last
);
  import bmf_pkg::*;

  // ring of the most recent pixels; a window spans 2*width+3 positions
  localparam int DEPTH = 2 ** $clog2(2 * MAX_WIDTH + 3);
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int EW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = CFG_HEIGHT_BITS;
  localparam int RW    = ROW_BITS;
  localparam int SW    = PIXEL_BITS + 4;
  localparam int K     = PIXEL_BITS + 8;
  localparam int PW    = SW + K + 1;

  // ceil(2^K / n): exact truncating division for all sums that occur
  localparam logic [K:0] RECIP1 = (K + 1)'(1 << K);
  localparam logic [K:0] RECIP2 = (K + 1)'((1 << K) / 2);
  localparam logic [K:0] RECIP3 = (K + 1)'(((1 << K) + 2) / 3);
  localparam logic [K:0] RECIP4 = (K + 1)'((1 << K) / 4);
  localparam logic [K:0] RECIP6 = (K + 1)'(((1 << K) + 5) / 6);
  localparam logic [K:0] RECIP9 = (K + 1)'(((1 << K) + 8) / 9);

  logic [CFG_WIDTH_BITS-1:0] fw_reg;
  logic [HW-1:0]             fh_reg;
  logic [EW-1:0]             w_eff;
  logic [HW-1:0]             h_eff;

  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [AW-1:0] in_addr;
  logic          full;
  logic [CW-1:0] out_col;
  logic [RW-1:0] out_row;
  logic [AW-1:0] out_addr;

  logic [1:0]            rd_dx;
  logic [1:0]            rd_dy;
  logic [AW-1:0]         rd_base;
  logic [AW-1:0]         rd_addr;
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  take_d;
  logic                  in_frame;
  logic [SW-1:0]         sum;
  logic [3:0]            cnt;
  logic [K:0]            recip;
  logic [PW-1:0]         prod;
  logic                  last_pend;

  logic in_col_end;
  logic in_row_end;
  logic out_col_end;
  logic out_row_end;

  always_comb begin
    if (fw_reg == '0) begin
      w_eff = EW'(1);
    end else if (int'(fw_reg) > MAX_WIDTH) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(fw_reg);
    end
    if (fh_reg == '0) begin
      h_eff = HW'(1);
    end else if (fh_reg > HW'(HEIGHT_LIMIT)) begin
      h_eff = HW'(HEIGHT_LIMIT);
    end else begin
      h_eff = fh_reg;
    end
  end

  assign in_col_end  = (EW'(in_col) == w_eff - EW'(1));
  assign in_row_end  = (HW'(in_row) == h_eff - HW'(1));
  assign out_col_end = (EW'(out_col) == w_eff - EW'(1));
  assign out_row_end = (HW'(out_row) == h_eff - HW'(1));

  // drop neighbors that fall outside the frame
  assign in_frame = !((rd_dy == 2'd0) && (out_row == '0)) &&
                    !((rd_dy == 2'd2) && out_row_end) &&
                    !((rd_dx == 2'd0) && (out_col == '0)) &&
                    !((rd_dx == 2'd2) && out_col_end);

  assign rd_addr = rd_base + AW'(rd_dx);

  always_comb begin
    status.is_pixel = (req_type == REQ_PIXEL) && !full;
    // first result is due once one row and one pixel are in
    status.out_due  = (in_row >= RW'(2)) || ((in_row == RW'(1)) && (in_col != '0));
    status.full     = full;
    status.rd_done  = (rd_dx == 2'd2) && (rd_dy == 2'd2);
    status.out_busy = mean_valid && !mean_ready;
  end

  always_comb begin
    case (cnt)
      4'd1:    recip = RECIP1;
      4'd2:    recip = RECIP2;
      4'd3:    recip = RECIP3;
      4'd4:    recip = RECIP4;
      4'd6:    recip = RECIP6;
      4'd9:    recip = RECIP9;
      default: recip = '0;
    endcase
  end

  bmf_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.take_pixel),
    .waddr (in_addr),
    .wdata (pixel_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fw_reg     <= CFG_WIDTH_BITS'(WIDTH_RESET);
      fh_reg     <= HW'(HEIGHT_RESET);
      in_col     <= '0;
      in_row     <= '0;
      in_addr    <= '0;
      full       <= 1'b0;
      out_col    <= '0;
      out_row    <= '0;
      out_addr   <= '0;
      rd_dx      <= '0;
      rd_dy      <= '0;
      take_d     <= 1'b0;
      mean_valid <= 1'b0;
    end else begin
      take_d <= cmd.read && in_frame;

      if (cmd.start) begin
        rd_dx <= '0;
        rd_dy <= '0;
      end else if (cmd.read) begin
        if (rd_dx == 2'd2) begin
          rd_dx <= '0;
          rd_dy <= rd_dy + 2'd1;
        end else begin
          rd_dx <= rd_dx + 2'd1;
        end
      end

      if (cmd.take_pixel) begin
        in_addr <= in_addr + AW'(1);
        if (in_col_end) begin
          in_col <= '0;
          if (in_row_end) begin
            in_row <= '0;
            full   <= 1'b1;
          end else begin
            in_row <= in_row + RW'(1);
          end
        end else begin
          in_col <= in_col + CW'(1);
        end
      end

      if (mean_valid && mean_ready) begin
        mean_valid <= 1'b0;
      end

      if (cmd.load) begin
        mean_valid <= 1'b1;
        if (last_pend) begin
          // final result of the frame: ready for a new one
          in_col   <= '0;
          in_row   <= '0;
          in_addr  <= '0;
          full     <= 1'b0;
          out_col  <= '0;
          out_row  <= '0;
          out_addr <= '0;
        end else begin
          out_addr <= out_addr + AW'(1);
          if (out_col_end) begin
            out_col <= '0;
            out_row <= out_row + RW'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  fw_reg <= cfg_data[CFG_WIDTH_BITS-1:0];
          REG_FRAME_HEIGHT: fh_reg <= cfg_data;
          default: ;
        endcase
        in_col   <= '0;
        in_row   <= '0;
        in_addr  <= '0;
        full     <= 1'b0;
        out_col  <= '0;
        out_row  <= '0;
        out_addr <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_base   <= out_addr - AW'(w_eff) - AW'(1);
      sum       <= '0;
      cnt       <= '0;
      last_pend <= !status.is_pixel && out_row_end && out_col_end;
    end else begin
      if (cmd.read) begin
        cnt <= cnt + 4'(in_frame);
        if (rd_dx == 2'd2) begin
          rd_base <= rd_base + AW'(w_eff);
        end
      end
      if (take_d) begin
        sum <= sum + SW'(rd_data);
      end
    end

    if (cmd.mul) begin
      prod <= PW'(sum) * PW'(recip);
    end

    if (cmd.load) begin
      mean_value <= prod[K +: PIXEL_BITS];
      frame_last <= last_pend;
    end
  end

endmodule

`default_nettype wire

FILE: sv/box_mean_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// box_mean_filter_3x3_unit
// 3x3 box mean filter over a raster pixel stream, edge-aware truncating mean.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload                   Transfer
// pixels   in         req_type, pixel_value     valid & ready
// means    out        mean_value, frame_last    valid & ready
// cfg      in         cfg_index, cfg_data       cfg_we (0 = width, 1 = height)
//
// An item that yields a result runs nine ring RAM reads (one read port), then
// the last add, multiply and load; the next item is taken after that load.
// An item with no result leaves the block idle and ready for the next item.
// Reset (synchronous) gives an 80 x 21 frame and an empty pipeline.
// The result register holds a stalled result; the next item is still taken,
// and only the load of its result waits for means.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module box_mean_filter_3x3_unit #(
  parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = bmf_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bmf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bmf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  bmf_pix_if.sink                            pixels,
  bmf_mean_if.source                         means
);
  import bmf_pkg::*;

  cmd_t    cmd;
  status_t status;

  bmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (pixels.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bmf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (pixels.req_type),
    .pixel_value (pixels.pixel_value),
    .cmd         (cmd),
    .status      (status),
    .mean_valid  (means.valid),
    .mean_ready  (means.ready),
    .mean_value  (means.mean_value),
    .frame_last  (means.frame_last)
  );

endmodule

`default_nettype wire

FILE: sv/bmf_checker.sv
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks of the mean filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_mean_filter_3x3_unit_assert.svh"

module bmf_checker #(
  parameter int PIXEL_BITS = bmf_pkg::PIXEL_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PIXEL_BITS-1:0] mean_value,
  input logic                  frame_last
);

  `BMF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "stalled result dropped")
  `BMF_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(mean_value) && $stable(frame_last), "stalled result changed")
  `BMF_ASSERT_RESET(a_reset_state, clk, rst, !out_valid && in_ready, "block not idle after reset")
  `BMF_ASSERT_NOW(a_busy_cause, clk, rst, $fell(in_ready), $past(in_valid), "went busy without an item")

endmodule

bind box_mean_filter_3x3_unit bmf_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_bmf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pixels.valid),
  .in_ready   (pixels.ready),
  .out_valid  (means.valid),
  .out_ready  (means.ready),
  .mean_value (means.mean_value),
  .frame_last (means.frame_last)
);

`default_nettype wire

FILE: sim/tb_box_mean_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// tb_box_mean_filter_3x3_unit
// Streams raster frames and drain items through the 3x3 mean filter, keeps a
// copy of the current frame to work out every edge-aware mean, and checks each
// result in order under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb_box_mean_filter_3x3_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bmf_pkg::*;

  localparam logic REQ_DRAIN      = 1'b1;
  localparam int   SETTLE_CYCLES  = 20;
  localparam int   RANDOM_ITEMS   = 560;
  localparam int   REPORT_LIMIT   = 10;
  localparam int   FRAME_CAPACITY = MAX_WIDTH_DEF * HEIGHT_LIMIT;

  typedef struct packed {
    logic [PIXEL_BITS_DEF-1:0] mean_value;
    logic                      frame_last;
  } mean_item_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  bmf_pix_if  pix_ch ();
  bmf_mean_if mean_ch ();

  box_mean_filter_3x3_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_ch),
    .means     (mean_ch)
  );

  // Filter state as seen from outside: registers, frame geometry, positions
  int unsigned               raw_width;
  int unsigned               raw_height;
  int unsigned               act_w;
  int unsigned               act_h;
  int unsigned               next_in;
  int unsigned               next_out;
  bit                        frame_done;
  logic [PIXEL_BITS_DEF-1:0] frame_pixels [FRAME_CAPACITY];
  mean_item_t                expected_means [$];

  int error_count    = 0;
  int useful_items   = 0;
  int burst_left     = 0;
  int holdoff_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void log_failure(string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("[%0t] MISMATCH %s", $time, msg);
    end
  endfunction

  function automatic void restart_frame();
    next_in    = 0;
    next_out   = 0;
    frame_done = 1'b0;
  endfunction

  function automatic void apply_geometry();
    act_w = (raw_width == 0) ? 1 : (raw_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : raw_width;
    act_h = (raw_height == 0) ? 1 : (raw_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : raw_height;
    restart_frame();
  endfunction

  // Mean over the in-frame part of the 3x3 window around stream position pos
  function automatic logic [PIXEL_BITS_DEF-1:0] neighborhood_mean(int unsigned pos);
    int          row;
    int          col;
    int          y;
    int          x;
    int unsigned sum;
    int unsigned cnt;
    row = pos / act_w;
    col = pos % act_w;
    sum = 0;
    cnt = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        y = row + dy;
        x = col + dx;
        if (y >= 0 && x >= 0 && y < int'(act_h) && x < int'(act_w)) begin
          sum += frame_pixels[y * act_w + x];
          cnt++;
        end
      end
    end
    return PIXEL_BITS_DEF'(sum / cnt);
  endfunction

  function automatic void predict_means(logic kind, logic [PIXEL_BITS_DEF-1:0] value);
    int unsigned total;
    int unsigned pos;
    total = act_w * act_h;
    if (kind == REQ_PIXEL && !frame_done) begin
      pos = next_in;
      frame_pixels[pos] = value;
      useful_items++;
      next_in = pos + 1;
      if (next_in >= total) begin
        next_in    = 0;
        frame_done = 1'b1;
      end
      // output runs one row and one pixel behind the input
      if (pos >= act_w + 1) begin
        expected_means.push_back('{neighborhood_mean(next_out), 1'b0});
        next_out++;
      end
    end else if (frame_done) begin
      useful_items++;
      if (next_out + 1 >= total) begin
        expected_means.push_back('{neighborhood_mean(next_out), 1'b1});
        restart_frame();
      end else begin
        expected_means.push_back('{neighborhood_mean(next_out), 1'b0});
        next_out++;
      end
    end
  endfunction

  function automatic logic [PIXEL_BITS_DEF-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      default: begin
        return PIXEL_BITS_DEF'($urandom);
      end
    endcase
  endfunction

  task automatic send_item(input logic kind, input logic [PIXEL_BITS_DEF-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    pix_ch.valid       <= 1'b1;
    pix_ch.req_type    <= kind;
    pix_ch.pixel_value <= value;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    predict_means(kind, value);
  endtask

  task automatic send_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(REQ_PIXEL, pick_pixel());
    end
  endtask

  // Push out the pending results; a pixel while the frame is full acts as a drain
  task automatic flush_frame();
    while (frame_done) begin
      send_item(($urandom_range(0, 3) == 0) ? REQ_PIXEL : REQ_DRAIN, pick_pixel());
    end
  endtask

  task automatic wait_drained();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
    // an item with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) begin
      raw_width = value[CFG_WIDTH_BITS-1:0];
    end else begin
      raw_height = value[CFG_HEIGHT_BITS-1:0];
    end
    apply_geometry();
  endtask

  task automatic configure(input logic [CFG_DATA_BITS-1:0] width_val,
                           input logic [CFG_DATA_BITS-1:0] height_val);
    write_reg(REG_FRAME_WIDTH, width_val);
    write_reg(REG_FRAME_HEIGHT, height_val);
  endtask

  // Receiver: stall phases of random density, plus a requested long hold-off
  initial begin
    int phase_left;
    int stall_pct;
    phase_left = 0;
    stall_pct  = 0;
    mean_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_cycles > 0) begin
        holdoff_cycles--;
        mean_ch.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          case ($urandom_range(0, 4))
            0, 1: begin
              stall_pct = 0;
            end
            2: begin
              stall_pct = 20;
            end
            3: begin
              stall_pct = 50;
            end
            default: begin
              stall_pct = 85;
            end
          endcase
          phase_left = $urandom_range(16, 96);
        end
        phase_left--;
        mean_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_means
    mean_item_t want;
    if (!rst && mean_ch.valid && mean_ch.ready) begin
      if (expected_means.size() == 0) begin
        log_failure($sformatf("unexpected result mean_value=%0d frame_last=%0b",
                              mean_ch.mean_value, mean_ch.frame_last));
      end else begin
        want = expected_means.pop_front();
        if (mean_ch.mean_value !== want.mean_value) begin
          log_failure($sformatf("mean_value expected %0d got %0d",
                                want.mean_value, mean_ch.mean_value));
        end
        if (mean_ch.frame_last !== want.frame_last) begin
          log_failure($sformatf("frame_last expected %0b got %0b",
                                want.frame_last, mean_ch.frame_last));
        end
      end
    end
  end

  // Partial frame at the reset geometry of 80 x 21
  task automatic test_reset_defaults();
    send_pixels(45);
    send_item(REQ_DRAIN, pick_pixel());
    send_pixels(45);
  endtask

  task automatic test_corner_frames();
    logic [PIXEL_BITS_DEF-1:0] corner_pixels [9];
    corner_pixels = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01};
    wait_drained();
    configure(11'd3, 11'd3);
    send_item(REQ_DRAIN, 8'hFF);
    for (int i = 0; i < 9; i++) begin
      // drain mid-frame: ignored
      if (i == 4) begin
        send_item(REQ_DRAIN, 8'h00);
      end
      send_item(REQ_PIXEL, corner_pixels[i]);
    end
    send_item(REQ_PIXEL, 8'hA5);
    flush_frame();
    send_item(REQ_DRAIN, 8'h00);
    wait_drained();
    // zero width and height act as one
    configure(11'd0, 11'd0);
    send_item(REQ_PIXEL, 8'hC3);
    send_item(REQ_DRAIN, 8'h3C);
    wait_drained();
    // upper data bits are dropped by the width register
    write_reg(REG_FRAME_WIDTH, 11'h702);
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    send_item(REQ_PIXEL, 8'hFF);
    send_item(REQ_PIXEL, 8'h00);
    send_item(REQ_PIXEL, 8'hFF);
    send_item(REQ_PIXEL, 8'hFF);
    flush_frame();
  endtask

  task automatic test_register_extremes();
    wait_drained();
    configure(11'd255, 11'd1);
    send_pixels(MAX_WIDTH_DEF);
    flush_frame();
    wait_drained();
    configure(11'd128, 11'd2047);
    send_pixels(140);
    wait_drained();
    configure(11'd1, 11'd1024);
    send_pixels(30);
  endtask

  // Hold off the receiver while the sender keeps offering a whole frame
  task automatic test_backpressure();
    wait_drained();
    configure(11'd6, 11'd6);
    holdoff_cycles = 400;
    send_pixels(36);
    flush_frame();
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned total;
    int unsigned n_pix;
    int unsigned pause_at;
    int unsigned cls;
    int unsigned w_raw;
    int unsigned h_raw;
    bit          need_cfg;
    bit          abort;
    start    = useful_items;
    need_cfg = 1'b1;
    while (useful_items - start < RANDOM_ITEMS) begin
      if (need_cfg || $urandom_range(0, 2) != 0) begin
        wait_drained();
        cls = $urandom_range(0, 99);
        if (cls < 70) begin
          w_raw = $urandom_range(1, 12);
          h_raw = $urandom_range(1, 8);
        end else if (cls < 82) begin
          w_raw = $urandom_range(13, 48);
          h_raw = $urandom_range(1, 4);
        end else if (cls < 88) begin
          w_raw = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(129, 255);
          h_raw = $urandom_range(1, 2);
        end else begin
          w_raw = $urandom_range(1, 6);
          case ($urandom_range(0, 2))
            0: begin
              h_raw = 0;
            end
            1: begin
              h_raw = $urandom_range(1025, 2047);
            end
            default: begin
              h_raw = $urandom_range(9, 1024);
            end
          endcase
        end
        if ($urandom_range(0, 5) == 0) begin
          // width only, with junk in the upper data bits; height stays
          write_reg(REG_FRAME_WIDTH, 11'(w_raw) | (11'($urandom_range(1, 7)) << 8));
        end else begin
          configure(11'(w_raw), 11'(h_raw));
        end
      end
      total    = act_w * act_h;
      abort    = (total > 400) || (total > 1 && $urandom_range(0, 9) == 0);
      n_pix    = abort ? $urandom_range(1, (total - 1 < 80) ? total - 1 : 80) : total;
      pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n_pix - 1) : n_pix;
      for (int i = 0; i < n_pix; i++) begin
        if (i == pause_at) begin
          wait_drained();
        end
        if ($urandom_range(0, 19) == 0) begin
          send_item(REQ_DRAIN, pick_pixel());
        end
        send_item(REQ_PIXEL, pick_pixel());
      end
      if (!abort) begin
        flush_frame();
        if ($urandom_range(0, 4) == 0) begin
          send_item(REQ_DRAIN, pick_pixel());
        end
      end
      need_cfg = abort;
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_FRAME_WIDTH;
    cfg_data           <= '0;
    pix_ch.valid       <= 1'b0;
    pix_ch.req_type    <= REQ_PIXEL;
    pix_ch.pixel_value <= '0;
    raw_width  = WIDTH_RESET;
    raw_height = HEIGHT_RESET;
    apply_geometry();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_corner_frames();
    test_register_extremes();
    test_backpressure();
    test_random_frames();
    wait_drained();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
